// File: sv/cipr_pkg.sv
// package for the capped inclusion probability rescaler: types and constants
package cipr_pkg;
  localparam int MAX_UNITS_DEF = 64;
  localparam int WEIGHT_BITS_DEF = 32;
  localparam int PROB_FRAC_BITS_DEF = 16;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_TOO_LARGE = 2'd1;
  localparam logic [1:0] ST_INCONSISTENT = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  typedef struct packed {
    logic [31:0] weight;
    logic        last_unit;
  } req_t;

  typedef struct packed {
    logic [5:0]  unit_index;
    logic [16:0] inclusion_prob;
    logic        capped;
    logic        zero_weight;
    logic [6:0]  capped_total;
    logic [6:0]  zero_total;
    logic [1:0]  status;
    logic        last_result;
  } rsp_t;

  typedef enum logic [2:0] {
    OP_NONE, OP_CLEAR, OP_LOAD, OP_EQ_CAP, OP_PASS_BEGIN, OP_PASS_TEST,
    OP_PASS_END, OP_OUT_READ
  } op_t;

  // controller to datapath
  typedef struct packed {
    op_t        op;
    logic [5:0] idx;
    logic       div_start;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [6:0] unit_count;
    logic [6:0] nz_count;
    logic       overflow;
    logic       pass_any;
    logic       fail_cap;
    logic       div_done;
    logic       rd_capped;
    logic       rd_zero;
  } sts_t;
endpackage

// File: sv/cipr_datapath.sv
// datapath: weight store, capping pass logic, fractional divider
module cipr_datapath #(
  parameter int MAX_UNITS = cipr_pkg::MAX_UNITS_DEF,
  parameter int WEIGHT_BITS = cipr_pkg::WEIGHT_BITS_DEF,
  parameter int PROB_FRAC_BITS = cipr_pkg::PROB_FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  cipr_pkg::cmd_t cmd,
  input  cipr_pkg::req_t req,
  input  logic [6:0]    sample_size,
  output cipr_pkg::sts_t sts,
  output logic [16:0]   quot,
  output logic [6:0]    capped_cnt,
  output logic [6:0]    zero_cnt
);
  import cipr_pkg::*;
  localparam int SB = WEIGHT_BITS + 7;
  localparam int PB = WEIGHT_BITS + 7;
  localparam int FB = $clog2(PROB_FRAC_BITS + 1);

  logic [WEIGHT_BITS-1:0] mem [MAX_UNITS];
  logic [WEIGHT_BITS-1:0] rd_w;
  logic [MAX_UNITS-1:0]   cflag;
  logic [6:0]             ucount;
  logic [SB-1:0]          usum, pass_s, removed;
  logic [6:0]             pass_rem, newly;
  logic                   ovf, any;
  logic [PB-1:0]          prod;
  logic [SB:0]            rr;
  logic [PROB_FRAC_BITS-1:0] qq;
  logic [FB-1:0]          dcnt;
  logic                   dbusy, ddone;
  logic [6:0]             nrem;
  logic [5:0]             ridx;
  logic [SB:0]            rsh;

  assign nrem = (sample_size > capped_cnt) ? sample_size - capped_cnt : 7'd0;
  assign prod = PB'(rd_w) * PB'(pass_rem);
  assign rsh = {rr[SB-1:0], 1'b0};

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD && !ucount[6] && ucount < 7'(MAX_UNITS))
      mem[ucount[5:0]] <= req.weight[WEIGHT_BITS-1:0];
    rd_w <= mem[cmd.idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cflag <= '0; ucount <= '0; capped_cnt <= '0; zero_cnt <= '0;
      usum <= '0; ovf <= 1'b0; dbusy <= 1'b0; ddone <= 1'b0; any <= 1'b0;
      pass_s <= '0; pass_rem <= '0; newly <= '0; removed <= '0;
      ridx <= '0; dcnt <= '0;
    end else begin
      ddone <= !cmd.div_start && dbusy && (dcnt == FB'(PROB_FRAC_BITS - 1));
      ridx <= cmd.idx;
      unique case (cmd.op)
        OP_CLEAR: begin
          cflag <= '0; ucount <= '0; capped_cnt <= '0; zero_cnt <= '0;
          usum <= '0; ovf <= 1'b0;
        end
        OP_LOAD: begin
          if (!ucount[6] && ucount < 7'(MAX_UNITS)) begin
            ucount <= ucount + 7'd1;
            if (req.weight[WEIGHT_BITS-1:0] == '0) zero_cnt <= zero_cnt + 7'd1;
            usum <= usum + SB'(req.weight[WEIGHT_BITS-1:0]);
          end else ovf <= 1'b1;
        end
        OP_EQ_CAP: begin
          if (rd_w != '0) cflag[ridx] <= 1'b1;
          capped_cnt <= ucount - zero_cnt;
          usum <= '0;
        end
        OP_PASS_BEGIN: begin
          pass_s <= usum; pass_rem <= nrem; newly <= '0; removed <= '0;
          any <= 1'b0;
        end
        OP_PASS_TEST: begin
          if (!cflag[ridx] && prod >= PB'(pass_s)) begin
            cflag[ridx] <= 1'b1;
            removed <= removed + SB'(rd_w);
            newly <= newly + 7'd1;
            any <= 1'b1;
          end
        end
        OP_PASS_END: begin
          capped_cnt <= capped_cnt + newly;
          usum <= pass_s - removed;
        end
        OP_OUT_READ, OP_NONE: ;
        default: ;
      endcase
      if (cmd.div_start) begin
        rr <= {1'b0, SB'(prod)};
        qq <= '0; dcnt <= '0; dbusy <= 1'b1;
      end else if (dbusy) begin
        if (rsh >= {1'b0, usum}) begin
          rr <= rsh - {1'b0, usum}; qq <= {qq[PROB_FRAC_BITS-2:0], 1'b1};
        end else begin
          rr <= rsh; qq <= {qq[PROB_FRAC_BITS-2:0], 1'b0};
        end
        dcnt <= dcnt + FB'(1);
        if (dcnt == FB'(PROB_FRAC_BITS - 1)) begin
          dbusy <= 1'b0;
        end
      end
      if (cmd.op == OP_OUT_READ) pass_rem <= nrem;
    end
  end

  assign quot = 17'(qq);
  assign sts.unit_count = ucount;
  assign sts.nz_count = ucount - zero_cnt;
  assign sts.overflow = ovf;
  assign sts.pass_any = any;
  assign sts.fail_cap = (capped_cnt >= sample_size) || (usum == '0);
  assign sts.div_done = ddone;
  assign sts.rd_capped = cflag[ridx];
  assign sts.rd_zero = (rd_w == '0);
endmodule

// File: sv/cipr_ctrl.sv
// controller state machine sequencing load, capping passes and output
module cipr_ctrl #(
  parameter int PROB_FRAC_BITS = cipr_pkg::PROB_FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  cipr_pkg::req_t req,
  input  logic [6:0]     sample_size,
  input  cipr_pkg::sts_t sts,
  input  logic [16:0]    quot,
  input  logic [6:0]     capped_cnt,
  input  logic [6:0]     zero_cnt,
  output logic           busy,
  output cipr_pkg::cmd_t cmd,
  output logic           strobe,
  output cipr_pkg::rsp_t result
);
  import cipr_pkg::*;
  typedef enum logic [3:0] {
    S_IDLE, S_LOADED, S_EQ_RD, S_EQ_WR, S_PB, S_PT_RD, S_PT, S_PE, S_PCHK,
    S_O_RD, S_O_WAIT, S_O_DEC, S_O_DIV, S_CLR
  } state_t;
  state_t state;
  logic [5:0] idx;
  logic accept;
  logic [6:0] last_i;
  logic strobe_next;
  assign accept = start && !busy;
  assign last_i = sts.unit_count - 7'd1;

  function automatic rsp_t err_rsp(logic [1:0] code);
    rsp_t r;
    r = '0;
    r.status = code;
    r.last_result = 1'b1;
    return r;
  endfunction

  assign strobe_next =
    ((state == S_LOADED) && (sts.overflow || sample_size > sts.nz_count))
    || ((state == S_PCHK) && !sts.pass_any && sts.fail_cap)
    || ((state == S_O_DEC) && (sts.rd_capped || sts.rd_zero))
    || ((state == S_O_DIV) && sts.div_done);

  always_comb begin
    cmd = '0;
    cmd.idx = idx;
    if (accept) cmd.op = OP_LOAD;
    unique case (state)
      S_EQ_WR: cmd.op = OP_EQ_CAP;
      S_PB: cmd.op = OP_PASS_BEGIN;
      S_PT: cmd.op = OP_PASS_TEST;
      S_PE: cmd.op = OP_PASS_END;
      S_O_RD: cmd.op = OP_OUT_READ;
      S_CLR: cmd.op = OP_CLEAR;
      default: ;
    endcase
    cmd.div_start = (state == S_O_DEC) && !sts.rd_capped && !sts.rd_zero;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; busy <= 1'b0; idx <= '0; strobe <= 1'b0;
    end else begin
      strobe <= strobe_next;
      unique case (state)
        S_IDLE: if (accept && req.last_unit) begin
          state <= S_LOADED; busy <= 1'b1;
        end
        S_LOADED: begin
          idx <= '0;
          if (sts.overflow || sample_size > sts.nz_count) begin
            result <= err_rsp(sts.overflow ? ST_OVERFLOW : ST_TOO_LARGE);
            state <= S_CLR;
          end else if (sample_size == sts.nz_count) state <= S_EQ_RD;
          else state <= S_PB;
        end
        S_EQ_RD: state <= S_EQ_WR;
        S_EQ_WR: if (7'(idx) == last_i) begin
          idx <= '0; state <= S_O_RD;
        end else begin
          idx <= idx + 6'd1; state <= S_EQ_RD;
        end
        S_PB: begin idx <= '0; state <= S_PT_RD; end
        S_PT_RD: state <= S_PT;
        S_PT: if (7'(idx) == last_i) state <= S_PE;
              else begin idx <= idx + 6'd1; state <= S_PT_RD; end
        S_PE: state <= S_PCHK;
        S_PCHK: if (sts.pass_any) state <= S_PB;
          else if (sts.fail_cap) begin
            result <= err_rsp(ST_INCONSISTENT); state <= S_CLR;
          end else begin idx <= '0; state <= S_O_RD; end
        S_O_RD: state <= S_O_WAIT;
        S_O_WAIT: state <= S_O_DEC;
        S_O_DEC: begin
          result.unit_index <= idx;
          result.capped <= sts.rd_capped;
          result.zero_weight <= sts.rd_zero;
          result.capped_total <= capped_cnt;
          result.zero_total <= zero_cnt;
          result.status <= ST_OK;
          result.last_result <= (7'(idx) == last_i);
          if (sts.rd_capped || sts.rd_zero) begin
            result.inclusion_prob <= sts.rd_capped ?
              17'(18'd1 << PROB_FRAC_BITS) : 17'd0;
            if (7'(idx) == last_i) state <= S_CLR;
            else begin idx <= idx + 6'd1; state <= S_O_RD; end
          end else state <= S_O_DIV;
        end
        S_O_DIV: if (sts.div_done) begin
          result.inclusion_prob <= quot;
          if (7'(idx) == last_i) state <= S_CLR;
          else begin idx <= idx + 6'd1; state <= S_O_RD; end
        end
        S_CLR: begin state <= S_IDLE; busy <= 1'b0; end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_load: assert property (@(posedge clk) disable iff (rst)
    (accept && req.last_unit) |=> busy) else $error("busy not raised");
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy) else $error("result outside run");
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.status != ST_OK) |-> result.last_result)
    else $error("error result not last");
endmodule

// File: sv/capped_inclusion_prob_rescale.sv
// top level of the capped inclusion probability rescaler
// Usage: weights arrive on req with start; a request is taken when start is
// high and busy is low; one unit loads per cycle while busy is low. The
// request that carries last_unit raises busy; the block then caps units in
// passes, each pass reading every stored unit (memory read, then test), or
// caps every nonzero unit when sample_size equals their count, and then
// emits one result per unit on result, marked by strobe for one cycle.
// Capped and zero units skip the bit-serial restoring divider; others use it.
// An error gives a single result with last_result set. The receiver cannot
// stall: every strobe is a delivered result. Busy drops in the cycle right
// after the last result and the run state is cleared. Reset clears the
// run state and sets sample_size to 1; cfg_ready is always high and
// sample_size may be written only while busy is low.
module capped_inclusion_prob_rescale #(
  parameter int MAX_UNITS = cipr_pkg::MAX_UNITS_DEF,
  parameter int WEIGHT_BITS = cipr_pkg::WEIGHT_BITS_DEF,
  parameter int PROB_FRAC_BITS = cipr_pkg::PROB_FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  cipr_pkg::req_t req,
  output logic           strobe,
  output cipr_pkg::rsp_t result,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [6:0]     cfg_data
);
  import cipr_pkg::*;
  cmd_t cmd;
  sts_t sts;
  logic [16:0] quot;
  logic [6:0] capped_cnt, zero_cnt, sample_size;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) sample_size <= 7'd1;
    else if (cfg_valid && cfg_ready) sample_size <= cfg_data;
  end

  cipr_datapath #(.MAX_UNITS(MAX_UNITS), .WEIGHT_BITS(WEIGHT_BITS),
    .PROB_FRAC_BITS(PROB_FRAC_BITS)) u_dp (
    .clk, .rst, .cmd, .req, .sample_size, .sts, .quot, .capped_cnt, .zero_cnt);

  cipr_ctrl #(.PROB_FRAC_BITS(PROB_FRAC_BITS)) u_ctrl (
    .clk, .rst, .start, .req, .sample_size, .sts, .quot, .capped_cnt,
    .zero_cnt, .busy, .cmd, .strobe, .result);
endmodule

// File: dv/capped_inclusion_prob_rescale_chk.sv
// checker for the capped inclusion probability rescaler: predicts and compares results
`timescale 1ns / 100ps
module capped_inclusion_prob_rescale_chk (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           busy,
  input  cipr_pkg::req_t req,
  input  logic           strobe,
  input  cipr_pkg::rsp_t result,
  input  logic           cfg_valid,
  input  logic           cfg_ready,
  input  logic [6:0]     cfg_data,
  output int             fail_count,
  output int             pending
);
  import cipr_pkg::*;

  localparam int NUNITS = MAX_UNITS_DEF;
  localparam int FRAC = PROB_FRAC_BITS_DEF;

  logic [6:0]  n_sample;
  logic [31:0] wt [NUNITS];
  logic        cap_flag [NUNITS];
  int          unit_cnt;
  int          cap_cnt;
  int          zero_cnt;
  logic [37:0] unc_sum;
  logic        ovf;
  rsp_t        expected_q [$];

  function automatic logic [16:0] scaled_prob(logic [63:0] num, logic [63:0] den);
    logic [63:0] r;
    logic [16:0] q;
    r = num;
    q = '0;
    for (int b = 0; b < FRAC; b++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  task automatic clear_population();
    for (int i = 0; i < NUNITS; i++) cap_flag[i] = 1'b0;
    unit_cnt = 0;
    cap_cnt = 0;
    zero_cnt = 0;
    unc_sum = '0;
    ovf = 1'b0;
  endtask

  task automatic push_error(logic [1:0] code);
    rsp_t r;
    r = '0;
    r.status = code;
    r.last_result = 1'b1;
    expected_q = {expected_q, r};
    clear_population();
  endtask

  task automatic rescale_population();
    int nz;
    int remn;
    int newly;
    logic [37:0] s;
    logic [37:0] removed;
    logic [63:0] prod;
    logic any;
    rsp_t r;
    nz = unit_cnt - zero_cnt;
    if (ovf) begin
      push_error(ST_OVERFLOW);
      return;
    end
    if (int'(n_sample) > nz) begin
      push_error(ST_TOO_LARGE);
      return;
    end
    if (int'(n_sample) == nz) begin
      for (int i = 0; i < unit_cnt; i++) cap_flag[i] = (wt[i] != 0);
      cap_cnt = nz;
      unc_sum = '0;
    end else begin
      do begin
        remn = (int'(n_sample) > cap_cnt) ? int'(n_sample) - cap_cnt : 0;
        s = unc_sum;
        newly = 0;
        removed = '0;
        any = 1'b0;
        for (int i = 0; i < unit_cnt; i++) begin
          prod = 64'(wt[i]) * 64'(remn);
          if (!cap_flag[i] && prod >= 64'(s)) begin
            cap_flag[i] = 1'b1;
            removed += 38'(wt[i]);
            newly++;
            any = 1'b1;
          end
        end
        cap_cnt += newly;
        unc_sum = s - removed;
      end while (any);
      if (cap_cnt >= int'(n_sample) || unc_sum == 0) begin
        push_error(ST_INCONSISTENT);
        return;
      end
    end
    for (int i = 0; i < unit_cnt; i++) begin
      r = '0;
      r.unit_index = 6'(i);
      if (cap_flag[i]) r.inclusion_prob = 17'(1 << FRAC);
      else if (wt[i] == 0) r.inclusion_prob = '0;
      else r.inclusion_prob = scaled_prob(64'(wt[i]) * 64'(int'(n_sample) - cap_cnt),
                                          64'(unc_sum));
      r.capped = cap_flag[i];
      r.zero_weight = (wt[i] == 0);
      r.capped_total = 7'(cap_cnt);
      r.zero_total = 7'(zero_cnt);
      r.status = ST_OK;
      r.last_result = (i + 1 == unit_cnt);
      expected_q = {expected_q, r};
    end
    clear_population();
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk) begin
    rsp_t e;
    if (rst) begin
      n_sample <= 7'd1;
      clear_population();
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) n_sample <= cfg_data;
      if (strobe) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result count", 32'd1, 32'd0);
        end else begin
          e = expected_q.pop_front();
          if (result.unit_index != e.unit_index)
            report_mismatch("unit_index", 32'(result.unit_index), 32'(e.unit_index));
          if (result.inclusion_prob != e.inclusion_prob)
            report_mismatch("inclusion_prob", 32'(result.inclusion_prob),
                            32'(e.inclusion_prob));
          if (result.capped != e.capped)
            report_mismatch("capped", 32'(result.capped), 32'(e.capped));
          if (result.zero_weight != e.zero_weight)
            report_mismatch("zero_weight", 32'(result.zero_weight), 32'(e.zero_weight));
          if (result.capped_total != e.capped_total)
            report_mismatch("capped_total", 32'(result.capped_total),
                            32'(e.capped_total));
          if (result.zero_total != e.zero_total)
            report_mismatch("zero_total", 32'(result.zero_total), 32'(e.zero_total));
          if (result.status != e.status)
            report_mismatch("status", 32'(result.status), 32'(e.status));
          if (result.last_result != e.last_result)
            report_mismatch("last_result", 32'(result.last_result), 32'(e.last_result));
        end
      end
      if (start && !busy) begin
        if (unit_cnt < NUNITS) begin
          wt[unit_cnt] = req.weight;
          cap_flag[unit_cnt] = 1'b0;
          unit_cnt++;
          if (req.weight == 0) zero_cnt++;
          unc_sum += 38'(req.weight);
        end else begin
          ovf = 1'b1;
        end
        if (req.last_unit) rescale_population();
      end
    end
    pending <= expected_q.size();
  end
endmodule

// File: dv/capped_inclusion_prob_rescale_tb.sv
// testbench top for the capped inclusion probability rescaler: stimulus and verdict
`timescale 1ns / 100ps
module capped_inclusion_prob_rescale_tb;
  import cipr_pkg::*;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  req_t       req = '0;
  logic       strobe;
  rsp_t       result;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [6:0] cfg_data = '0;
  int         fail_count;
  int         pending;
  int         idle_cycles = 0;
  int         burst_left = 0;
  int         items_sent = 0;

  localparam int WATCHDOG = 50000;

  always #1 clk = ~clk;

  capped_inclusion_prob_rescale u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .strobe(strobe), .result(result), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  capped_inclusion_prob_rescale_chk u_chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .strobe(strobe), .result(result), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("capped_inclusion_prob_rescale_tb failed");
      $finish;
    end
  end

  // one request, with bursty gaps before it
  task automatic send_unit(logic [31:0] w, logic lst);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    req <= '{weight: w, last_unit: lst};
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic set_sample(logic [6:0] n);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= n;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_weight();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(1, 255);
      3: return $urandom_range(32'h1_0000, 32'h10_0000);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_population(int cnt);
    for (int i = 0; i < cnt; i++) send_unit(rand_weight(), i == cnt - 1);
  endtask

  initial begin
    int sz;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed
    send_unit(32'd5, 1'b1);
    send_unit(32'd0, 1'b1);
    send_unit(32'hFFFF_FFFF, 1'b0);
    send_unit(32'd1, 1'b0);
    send_unit(32'd0, 1'b1);
    set_sample(7'd2);
    send_unit(32'd100, 1'b0);
    send_unit(32'd100, 1'b0);
    send_unit(32'd100, 1'b0);
    send_unit(32'hFFFF_FFFF, 1'b1);
    send_unit(32'd7, 1'b0);
    send_unit(32'd9, 1'b1);
    set_sample(7'd0);
    send_unit(32'd3, 1'b0);
    send_unit(32'd0, 1'b1);
    send_unit(32'd0, 1'b1);
    set_sample(7'd127);
    send_unit(32'hAAAA_5555, 1'b1);
    set_sample(7'd64);
    for (int i = 0; i < 65; i++) send_unit(32'h5555_AAAA + i, i == 64);
    for (int i = 0; i < 64; i++) send_unit(32'h0001_0000 + i, i == 63);
    // random
    while (items_sent < 420) begin
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 4))
          0: set_sample(7'd1);
          1: set_sample(7'd64);
          2: set_sample(7'($urandom_range(65, 127)));
          default: set_sample(7'($urandom_range(0, 12)));
        endcase
      end
      sz = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 66) : $urandom_range(1, 16);
      send_population(sz);
    end
    drain();
    if (fail_count == 0) $display("capped_inclusion_prob_rescale_tb passed");
    else $display("capped_inclusion_prob_rescale_tb failed");
    $finish;
  end
endmodule
